// File: sv/brvm_pkg.sv
`timescale 1ns / 1ps

package brvm_pkg;

   localparam int SAMPLE_W  = 16;
   localparam int SUM_W     = 43;
   localparam int TALLY_W   = 13;
   localparam int MAX_BLOCK = 4096;
   localparam int SCALED_W  = 49;
   localparam int QUOT_W    = 33;
   localparam int ROOT_W    = 17;
   localparam int VOLUME_W  = 17;

   localparam logic [VOLUME_W-1:0] FULL_SCALE = VOLUME_W'(65536);

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       last_in_block;
   } req_type;

   typedef struct packed {
      logic [VOLUME_W-1:0] volume;
      logic                saturated;
   } rsp_type;

   typedef struct packed {
      logic [SUM_W-1:0]   square_sum;
      logic [TALLY_W-1:0] sample_tally;
   } blk_type;

endpackage

// File: sv/brvm_front.sv
`timescale 1ns / 1ps

module brvm_front import brvm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  req_type req_item,
   input  logic    queue_full,
   output logic    blk_push,
   output blk_type blk_data
);

   logic [SUM_W-1:0]      square_sum_ff, square_sum_in;
   logic [TALLY_W-1:0]    sample_tally_ff, sample_tally_in;
   logic [SAMPLE_W-1:0]   mag;
   logic [2*SAMPLE_W-1:0] mag_sq;
   logic [SUM_W-1:0]      sum_next;
   logic [TALLY_W-1:0]    tally_next;
   logic                  accept;
   logic                  close;

   assign accept = push && !queue_full;

   // magnitude of the most negative sample still fits 16 unsigned bits
   assign mag = req_item.sample[SAMPLE_W-1] ? SAMPLE_W'(-req_item.sample)
                                            : SAMPLE_W'(req_item.sample);
   assign mag_sq     = mag * mag;
   assign sum_next   = square_sum_ff + SUM_W'(mag_sq);
   assign tally_next = sample_tally_ff + TALLY_W'(1);
   assign close      = req_item.last_in_block || (tally_next == TALLY_W'(MAX_BLOCK));

   assign blk_push            = accept && close;
   assign blk_data.square_sum   = sum_next;
   assign blk_data.sample_tally = tally_next;

   always_comb begin
      square_sum_in   = square_sum_ff;
      sample_tally_in = sample_tally_ff;
      if (accept) begin
         if (close) begin
            square_sum_in   = '0;
            sample_tally_in = '0;
         end else begin
            square_sum_in   = sum_next;
            sample_tally_in = tally_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         square_sum_ff   <= '0;
         sample_tally_ff <= '0;
      end else begin
         square_sum_ff   <= square_sum_in;
         sample_tally_ff <= sample_tally_in;
      end
   end

endmodule

// File: sv/brvm_queue.sv
`timescale 1ns / 1ps

module brvm_queue import brvm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_en,
   input  blk_type wr_data,
   input  logic    rd_en,
   output blk_type rd_data,
   output logic    q_full,
   output logic    q_empty
);

   blk_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign q_full  = (count_ff == 2'd2);
   assign q_empty = (count_ff == 2'd0);
   assign rd_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = !wr_ptr_ff;
      end
      if (rd_en) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + 2'd1;
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: sv/brvm_back.sv
`timescale 1ns / 1ps

module brvm_back import brvm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    q_empty,
   input  blk_type q_data,
   output logic    q_pop,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_item
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CHECK = 3'd1;
   localparam logic [2:0] ST_DIV   = 3'd2;
   localparam logic [2:0] ST_SQRT  = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   localparam int DIV_CNT_W  = $clog2(QUOT_W);
   localparam int SQRT_CNT_W = $clog2(ROOT_W);
   localparam int REM_W      = TALLY_W + 1;
   localparam int SQ_IN_W    = 2 * ROOT_W;
   localparam int SQ_REM_W   = ROOT_W + 1;
   localparam int SQ_TRY_W   = ROOT_W + 3;

   logic [2:0]            state_ff, state_in;
   logic [SCALED_W-1:0]   scaled_ff, scaled_in;
   logic [TALLY_W-1:0]    n_ff, n_in;
   logic [QUOT_W-1:0]     dvd_ff, dvd_in;
   logic [TALLY_W-1:0]    drem_ff, drem_in;
   logic [DIV_CNT_W-1:0]  dcnt_ff, dcnt_in;
   logic [SQ_IN_W-1:0]    sq_x_ff, sq_x_in;
   logic [SQ_REM_W-1:0]   sq_rem_ff, sq_rem_in;
   logic [ROOT_W-1:0]     root_ff, root_in;
   logic [SQRT_CNT_W-1:0] scnt_ff, scnt_in;
   logic                  sat_ff, sat_in;
   logic                  out_valid_ff, out_valid_in;
   rsp_type               out_ff, out_in;

   logic [SCALED_W-1:0]   sum_ext;
   logic [SCALED_W-1:0]   scaled_calc;
   logic [SCALED_W-1:0]   limit;
   logic                  over;
   logic [REM_W-1:0]      div_try;
   logic                  div_bit;
   logic [TALLY_W-1:0]    drem_next;
   logic [QUOT_W-1:0]     dvd_next;
   logic [SQ_TRY_W-1:0]   sq_cur;
   logic [SQ_TRY_W-1:0]   sq_trial;
   logic                  sq_bit;
   logic [SQ_REM_W-1:0]   sq_rem_next;
   logic [ROOT_W-1:0]     root_next;
   logic                  out_load;

   // times 100 as 64 + 32 + 4
   assign sum_ext     = SCALED_W'(q_data.square_sum);
   assign scaled_calc = (sum_ext << 6) + (sum_ext << 5) + (sum_ext << 2);

   // level above full scale when 100*S > N * 2^32
   assign limit = SCALED_W'({n_ff, 32'd0});
   assign over  = scaled_ff > limit;

   // restoring divide, one quotient bit a cycle
   assign div_try   = {drem_ff, dvd_ff[QUOT_W-1]};
   assign div_bit   = div_try >= REM_W'(n_ff);
   assign drem_next = div_bit ? TALLY_W'(div_try - REM_W'(n_ff)) : TALLY_W'(div_try);
   assign dvd_next  = {dvd_ff[QUOT_W-2:0], div_bit};

   // digit-by-digit square root, two radicand bits a cycle
   assign sq_cur      = {sq_rem_ff, sq_x_ff[SQ_IN_W-1 -: 2]};
   assign sq_trial    = SQ_TRY_W'({root_ff, 2'b01});
   assign sq_bit      = sq_cur >= sq_trial;
   assign sq_rem_next = sq_bit ? SQ_REM_W'(sq_cur - sq_trial) : SQ_REM_W'(sq_cur);
   assign root_next   = {root_ff[ROOT_W-2:0], sq_bit};

   assign out_load = (state_ff == ST_DONE) && (!out_valid_ff || pop);
   assign q_pop    = (state_ff == ST_IDLE) && !q_empty;
   assign empty    = !out_valid_ff;
   assign rsp_item = out_ff;

   always_comb begin
      state_in  = state_ff;
      scaled_in = scaled_ff;
      n_in      = n_ff;
      dvd_in    = dvd_ff;
      drem_in   = drem_ff;
      dcnt_in   = dcnt_ff;
      sq_x_in   = sq_x_ff;
      sq_rem_in = sq_rem_ff;
      root_in   = root_ff;
      scnt_in   = scnt_ff;
      sat_in    = sat_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               scaled_in = scaled_calc;
               n_in      = q_data.sample_tally;
               state_in  = ST_CHECK;
            end
         end
         ST_CHECK: begin
            sat_in = over;
            if (over) begin
               state_in = ST_DONE;
            end else begin
               // quotient fits 33 bits here, so the upper bits seed the remainder
               dvd_in   = scaled_ff[QUOT_W-1:0];
               drem_in  = scaled_ff[QUOT_W+TALLY_W-1:QUOT_W];
               dcnt_in  = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            dvd_in  = dvd_next;
            drem_in = drem_next;
            dcnt_in = dcnt_ff + DIV_CNT_W'(1);
            if (dcnt_ff == DIV_CNT_W'(QUOT_W - 1)) begin
               sq_x_in   = SQ_IN_W'(dvd_next);
               sq_rem_in = '0;
               root_in   = '0;
               scnt_in   = '0;
               state_in  = ST_SQRT;
            end
         end
         ST_SQRT: begin
            sq_x_in   = {sq_x_ff[SQ_IN_W-3:0], 2'b00};
            sq_rem_in = sq_rem_next;
            root_in   = root_next;
            scnt_in   = scnt_ff + SQRT_CNT_W'(1);
            if (scnt_ff == SQRT_CNT_W'(ROOT_W - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_in.volume    = sat_ff ? FULL_SCALE : VOLUME_W'(root_ff);
         out_in.saturated = sat_ff;
         out_valid_in     = 1'b1;
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      scaled_ff <= scaled_in;
      n_ff      <= n_in;
      dvd_ff    <= dvd_in;
      drem_ff   <= drem_in;
      dcnt_ff   <= dcnt_in;
      sq_x_ff   <= sq_x_in;
      sq_rem_ff <= sq_rem_in;
      root_ff   <= root_in;
      scnt_ff   <= scnt_in;
      sat_ff    <= sat_in;
      out_ff    <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

// File: sv/block_rms_volume_meter_top.sv
`timescale 1ns / 1ps

// Block RMS volume meter. Signed 16-bit samples are taken at one per cycle while full is
// low; each is squared and added to a running sum, and a block closes on a sample with
// last_in_block set or on its 4096th sample. A closed block's sum and count go into a
// two-entry queue, and a back-end unit turns each into one result: volume =
// floor(sqrt(100 * sum / count)) in unsigned Q1.16, or 65536 with saturated set when the
// level is above 1.0. The back end works on one block at a time: it scales the sum,
// checks for overrange, runs a bit-serial divide and a square root, and hands the
// result to the output register; a saturated block skips the divide and the root. full
// rises while two closed blocks wait in the queue, so blocks shorter than the back end's
// time per block, or a result left unpopped, hold off the sample stream. Reset clears the
// running sum and count and the queue, and marks the output empty.
module block_rms_volume_meter_top import brvm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_item,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_item
);

   logic    blk_push;
   blk_type blk_data;
   logic    q_full;
   logic    q_empty;
   logic    q_pop;
   blk_type q_data;

   assign full = q_full;

   brvm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .req_item   (req_item),
      .queue_full (q_full),
      .blk_push   (blk_push),
      .blk_data   (blk_data)
   );

   brvm_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (blk_push),
      .wr_data (blk_data),
      .rd_en   (q_pop),
      .rd_data (q_data),
      .q_full  (q_full),
      .q_empty (q_empty)
   );

   brvm_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_data   (q_data),
      .q_pop    (q_pop),
      .empty    (empty),
      .pop      (pop),
      .rsp_item (rsp_item)
   );

endmodule

// File: bench/block_rms_volume_meter_checker.sv
`timescale 1ns / 1ps

module block_rms_volume_meter_checker import brvm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  logic    full,
   input  req_type req_item,
   input  logic    empty,
   input  logic    pop,
   input  rsp_type rsp_item,
   output int      fail_count,
   output int      pending_count
);

   localparam int REPORT_LIMIT = 10;

   longint unsigned energy_acc;
   int unsigned     count_acc;
   rsp_type         expected_levels[$];
   int              fails;

   function automatic longint unsigned int_sqrt(input longint unsigned x);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      // quotient never exceeds 2^33 here, so 18 root bits are plenty
      for (int i = 17; i >= 0; i--) begin
         trial = root | (64'd1 << i);
         if (trial * trial <= x) begin
            root = trial;
         end
      end
      return root;
   endfunction

   function automatic rsp_type block_level(input longint unsigned energy,
                                           input int unsigned count);
      rsp_type         lvl;
      longint unsigned scaled;
      longint unsigned ceiling;
      scaled  = 64'd100 * energy;
      ceiling = longint'(count) << 32;
      lvl.saturated = (scaled > ceiling);
      if (lvl.saturated) begin
         lvl.volume = FULL_SCALE;
      end else begin
         lvl.volume = VOLUME_W'(int_sqrt(scaled / count));
      end
      return lvl;
   endfunction

   always @(posedge clock) begin : watch
      rsp_type         want;
      int              s;
      longint unsigned mag;
      if (reset) begin
         energy_acc = 0;
         count_acc  = 0;
         expected_levels.delete();
      end else begin
         // result side first: nothing pushed at this edge can already be out
         if (pop && !empty) begin
            if (expected_levels.size() == 0) begin
               fails++;
               if (fails <= REPORT_LIMIT) begin
                  $display("unexpected result: volume %0d saturated %0b",
                           rsp_item.volume, rsp_item.saturated);
               end
            end else begin
               want = expected_levels.pop_front();
               if (rsp_item !== want) begin
                  fails++;
                  if (fails <= REPORT_LIMIT) begin
                     $display("mismatch: expected volume %0d saturated %0b",
                              want.volume, want.saturated);
                     $display("          got volume %0d saturated %0b",
                              rsp_item.volume, rsp_item.saturated);
                  end
               end
            end
         end
         if (push && !full) begin
            s   = int'(req_item.sample);
            mag = longint'((s < 0) ? -s : s);
            energy_acc += mag * mag;
            count_acc++;
            // overlong block closes on its own
            if (req_item.last_in_block || count_acc == MAX_BLOCK) begin
               expected_levels = {expected_levels, block_level(energy_acc, count_acc)};
               energy_acc = 0;
               count_acc  = 0;
            end
         end
      end
      fail_count    <= fails;
      pending_count <= expected_levels.size();
   end

endmodule

// File: bench/block_rms_volume_meter_top_test.sv
`timescale 1ns / 1ps

module block_rms_volume_meter_top_test;
   import brvm_pkg::*;

   typedef enum int {AMP_ANY, AMP_EDGE, AMP_QUIET, AMP_EXTREME} amp_kind_type;

   localparam int HOLD_CYCLES  = 3000;
   localparam int DRAIN_CYCLES = 120;
   localparam int PHASE_ITEMS  = 420;
   localparam int REQ_W        = $bits(req_type);

   logic    clock;
   logic    reset    = 1'b1;
   logic    push     = 1'b0;
   logic    pop      = 1'b0;
   req_type req_item = '0;
   logic    full;
   logic    empty;
   rsp_type rsp_item;

   int fail_count;
   int pending_count;

   int send_idle_pct  = 0;
   int take_stall_pct = 0;
   bit hold_wanted    = 1'b0;
   bit hold_done      = 1'b0;
   int hold_count     = 0;

   block_rms_volume_meter_top i_dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_item (req_item),
      .empty    (empty),
      .pop      (pop),
      .rsp_item (rsp_item)
   );

   block_rms_volume_meter_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_item      (req_item),
      .empty         (empty),
      .pop           (pop),
      .rsp_item      (rsp_item),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #8_000_000;
      $display("simulation failed");
      $finish;
   end

   // result side: random stalls, plus one long hold-off to back up the input
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else if (hold_wanted && !hold_done) begin
         pop <= 1'b0;
         if (hold_count == HOLD_CYCLES) begin
            hold_done <= 1'b1;
         end
         hold_count <= hold_count + 1;
      end else begin
         pop <= ($urandom_range(0, 99) >= take_stall_pct);
      end
   end

   task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input bit last);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         push     <= 1'b0;
         req_item <= req_type'(REQ_W'($urandom));
         @(posedge clock);
      end
      push     <= 1'b1;
      req_item <= '{sample: s, last_in_block: last};
      do @(posedge clock); while (full);
   endtask

   function automatic logic signed [SAMPLE_W-1:0] pick_sample(input amp_kind_type kind);
      int mag;
      logic signed [SAMPLE_W-1:0] s;
      case (kind)
         AMP_EDGE: begin
            // around the clamp threshold of about 6554
            mag = $urandom_range(6400, 6700);
            s   = SAMPLE_W'($urandom_range(0, 1) ? -mag : mag);
         end
         AMP_QUIET: begin
            s = SAMPLE_W'(int'($urandom_range(0, 600)) - 300);
         end
         AMP_EXTREME: begin
            case ($urandom_range(0, 4))
               0: s = 16'sh7FFF;
               1: s = 16'sh8000;
               2: s = 16'sh0000;
               3: s = -16'sd1;
               default: s = 16'sd1;
            endcase
         end
         default: begin
            s = SAMPLE_W'($urandom);
         end
      endcase
      return s;
   endfunction

   task automatic send_block(input int len, input amp_kind_type kind);
      for (int i = 1; i <= len; i++) begin
         send_sample(pick_sample(kind), i == len);
      end
   endtask

   task automatic random_blocks(input int n_items);
      int sent;
      int len;
      int r;
      sent = 0;
      while (sent < n_items) begin
         r = $urandom_range(0, 99);
         if (r < 10) begin
            len = $urandom_range(1, 3);
         end else if (r < 80) begin
            len = $urandom_range(1, 24);
         end else begin
            len = $urandom_range(25, 150);
         end
         send_block(len, amp_kind_type'($urandom_range(0, 3)));
         sent += len;
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, zero, unit, both sides of the clamp threshold
      send_sample(16'sh7FFF, 1'b1);
      send_sample(16'sh8000, 1'b1);
      send_sample(16'sd0, 1'b1);
      send_sample(16'sd1, 1'b1);
      send_sample(16'sd6553, 1'b1);
      send_sample(-16'sd6554, 1'b1);
      // level of exactly 1.0: one -32768 among 25 samples
      repeat (24) send_sample(16'sd0, 1'b0);
      send_sample(16'sh8000, 1'b1);

      // no idling
      random_blocks(PHASE_ITEMS);

      send_idle_pct = 51;
      random_blocks(PHASE_ITEMS);

      send_idle_pct = 0;
      take_stall_pct <= 51;
      random_blocks(PHASE_ITEMS);

      send_idle_pct = 23;
      take_stall_pct <= 23;
      random_blocks(PHASE_ITEMS);

      // receiver holds off while short blocks keep coming
      send_idle_pct = 0;
      take_stall_pct <= 0;
      hold_wanted    <= 1'b1;
      repeat (40) send_block($urandom_range(1, 3), amp_kind_type'($urandom_range(0, 3)));

      push <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && pending_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
